@@ rtl/core/sgdmf_pkg.sv @@
`default_nettype none
package sgdmf_pkg;

    // row < 1024 and LATENT <= 128, so a word address never needs more than 17 bits
    localparam int ADDR_W = 17;

    localparam logic [2:0] KIND_WR_P  = 3'd0;
    localparam logic [2:0] KIND_WR_Q  = 3'd1;
    localparam logic [2:0] KIND_SMP_P = 3'd2;
    localparam logic [2:0] KIND_SMP_Q = 3'd3;
    localparam logic [2:0] KIND_RD_P  = 3'd4;
    localparam logic [2:0] KIND_RD_Q  = 3'd5;

    typedef struct packed {
        logic [2:0]         kind;
        logic [9:0]         row;
        logic [9:0]         col;
        logic [5:0]         lane;
        logic signed [31:0] value;
    } in_item_t;

    typedef struct packed {
        logic signed [31:0] read_value;
        logic signed [31:0] error_value;
        logic               saturated;
    } out_item_t;

    typedef enum logic [2:0] {
        OP_NOP,
        OP_WR_P,
        OP_WR_Q,
        OP_SMP_P,
        OP_SMP_Q,
        OP_RD_P,
        OP_RD_Q
    } op_t;

    typedef struct packed {
        op_t                op;
        logic [ADDR_W-1:0]  paddr;
        logic [ADDR_W-1:0]  qaddr;
        logic signed [31:0] value;
    } cmd_t;

endpackage
`default_nettype wire

@@ rtl/core/sgdmf_ram.sv @@
`default_nettype none
module sgdmf_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule
`default_nettype wire

@@ rtl/core/sgdmf_front.sv @@
`default_nettype none
module sgdmf_front
    import sgdmf_pkg::*;
#(
    parameter int ROWS   = 1024,
    parameter int COLS   = 1024,
    parameter int LATENT = 64
) (
    input  logic     clk,
    input  logic     rst_n,
    input  logic     push,
    output logic     full,
    input  in_item_t item,
    output logic     cmd_valid,
    output cmd_t     cmd,
    input  logic     cmd_pop
);

    // reciprocals for the index wrap; estimate is low by at most one
    localparam int MR = (1 << 20) / ROWS;
    localparam int MC = (1 << 20) / COLS;
    localparam int ML = (1 << 12) / LATENT;

    logic       s1_valid_reg, s1_valid_next;
    in_item_t   s1_item_reg;
    logic [9:0] s1_qr_reg, s1_qc_reg;
    logic [5:0] s1_ql_reg;

    logic [30:0] pr, pc;
    logic [18:0] pl;

    cmd_t        q_reg [2];
    logic        wr_ptr_reg, rd_ptr_reg;
    logic [1:0]  count_reg;
    logic        q_full, q_push, q_pop, accept;

    logic [31:0] rem_r, rem_c, rem_l, t_r, t_c, t_l, a_r, a_c;
    cmd_t        new_cmd;

    assign q_full = (count_reg == 2'd2);
    assign q_push = s1_valid_reg && !q_full;
    assign q_pop  = cmd_pop && (count_reg != 2'd0);
    assign full   = s1_valid_reg && q_full;
    assign accept = push && !full;

    assign cmd_valid = (count_reg != 2'd0);
    assign cmd       = q_reg[rd_ptr_reg];

    always_comb
    begin
        pr = 31'(item.row) * 31'(MR);
        pc = 31'(item.col) * 31'(MC);
        pl = 19'(item.lane) * 19'(ML);
        s1_valid_next = accept || (s1_valid_reg && q_full);
    end

    always_comb
    begin
        t_r = 32'(s1_qr_reg) * 32'(ROWS);
        t_c = 32'(s1_qc_reg) * 32'(COLS);
        t_l = 32'(s1_ql_reg) * 32'(LATENT);
        rem_r = 32'(s1_item_reg.row) - t_r;
        rem_c = 32'(s1_item_reg.col) - t_c;
        rem_l = 32'(s1_item_reg.lane) - t_l;
        if (rem_r >= 32'(ROWS))
        begin
            rem_r = rem_r - 32'(ROWS);
        end
        if (rem_c >= 32'(COLS))
        begin
            rem_c = rem_c - 32'(COLS);
        end
        if (rem_l >= 32'(LATENT))
        begin
            rem_l = rem_l - 32'(LATENT);
        end
        a_r = rem_r * 32'(LATENT);
        a_c = rem_c * 32'(LATENT);

        new_cmd.value = s1_item_reg.value;
        new_cmd.paddr = a_r[ADDR_W-1:0];
        new_cmd.qaddr = a_c[ADDR_W-1:0];
        case (s1_item_reg.kind)
            KIND_WR_P:
            begin
                new_cmd.op    = OP_WR_P;
                new_cmd.paddr = ADDR_W'(a_r + rem_l);
            end
            KIND_WR_Q:
            begin
                new_cmd.op    = OP_WR_Q;
                new_cmd.qaddr = ADDR_W'(a_c + rem_l);
            end
            KIND_SMP_P: new_cmd.op = OP_SMP_P;
            KIND_SMP_Q: new_cmd.op = OP_SMP_Q;
            KIND_RD_P:
            begin
                new_cmd.op    = OP_RD_P;
                new_cmd.paddr = ADDR_W'(a_r + rem_l);
            end
            KIND_RD_Q:
            begin
                new_cmd.op    = OP_RD_Q;
                new_cmd.qaddr = ADDR_W'(a_c + rem_l);
            end
            default:   new_cmd.op = OP_NOP;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            wr_ptr_reg   <= 1'b0;
            rd_ptr_reg   <= 1'b0;
            count_reg    <= 2'd0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
            if (q_push)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (q_pop)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            count_reg <= count_reg + 2'(q_push) - 2'(q_pop);
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_item_reg <= item;
            s1_qr_reg   <= pr[29:20];
            s1_qc_reg   <= pc[29:20];
            s1_ql_reg   <= pl[17:12];
        end
        if (q_push)
        begin
            q_reg[wr_ptr_reg] <= new_cmd;
        end
    end

endmodule
`default_nettype wire

@@ rtl/core/sgdmf_back.sv @@
`default_nettype none
module sgdmf_back
    import sgdmf_pkg::*;
#(
    parameter int ROWS   = 1024,
    parameter int COLS   = 1024,
    parameter int LATENT = 64
) (
    input  logic      clk,
    input  logic      rst_n,
    input  logic      cmd_valid,
    input  cmd_t      cmd,
    output logic      cmd_pop,
    input  logic [15:0] lr,
    input  logic [15:0] rg,
    output logic      res_valid,
    output out_item_t res,
    input  logic      res_pop
);

    localparam int PDEPTH = ROWS * LATENT;
    localparam int QDEPTH = COLS * LATENT;
    localparam int PAW = (PDEPTH > 1) ? $clog2(PDEPTH) : 1;
    localparam int QAW = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
    localparam int KW  = (LATENT > 1) ? $clog2(LATENT) : 1;
    localparam int SW  = 24;

    typedef enum logic [4:0] {
        ST_IDLE = 5'b00001,
        ST_READ = 5'b00010,
        ST_DOT  = 5'b00100,
        ST_ERR  = 5'b01000,
        ST_UPD  = 5'b10000
    } state_t;

    function automatic logic [32:0] sat_w(input logic signed [63:0] v);
        logic [32:0] r;
        if (v > 64'sd2147483647)
        begin
            r = {1'b1, 32'h7fff_ffff};
        end
        else if (v < -64'sd2147483648)
        begin
            r = {1'b1, 32'h8000_0000};
        end
        else
        begin
            r = {1'b0, v[31:0]};
        end
        return r;
    endfunction

    state_t state_reg, state_next;
    cmd_t   cur_reg, cur_next;
    logic [KW-1:0] k_reg, k_next;
    logic   issue_done_reg, issue_done_next;
    logic   flag_reg, flag_next;
    logic signed [31:0] err_reg, err_next;
    logic signed [63:0] sum_reg, sum_next;

    logic          d1_valid_reg, d1_valid_next, d2_valid_reg;
    logic [KW-1:0] d1_k_reg, d1_k_next;
    logic signed [63:0] prod_reg;

    logic          u1_valid_reg, u1_valid_next, u2_valid_reg, u3_valid_reg, u4_valid_reg;
    logic [KW-1:0] u1_k_reg, u1_k_next, u2_k_reg, u3_k_reg, u4_k_reg;
    logic signed [63:0] ey_reg;
    logic signed [48:0] rx_reg;
    logic signed [47:0] d16_reg;
    logic signed [64:0] ml_reg;
    logic signed [31:0] x2_reg, x3_reg, x4_reg;

    logic      res_valid_reg, res_valid_next;
    out_item_t res_reg, res_next;

    logic           p_we, q_we;
    logic [PAW-1:0] p_waddr, p_raddr;
    logic [QAW-1:0] q_waddr, q_raddr;
    logic [31:0]    p_wdata, q_wdata, p_rdata, q_rdata;
    logic [31:0]    cp_rdata, cq_rdata;
    logic [KW-1:0]  c_raddr;

    logic           upd_p, start;
    logic [SW-1:0]  pa_k, qa_k, pa_w, qa_w;
    logic signed [31:0] x1, y1;
    logic signed [63:0] d_full, diff;
    logic signed [48:0] delta;
    logic signed [63:0] new_x;
    logic [32:0]    sat_x, sat_e;

    sgdmf_ram #(.WIDTH(32), .DEPTH(PDEPTH)) u_p_ram (
        .clk(clk), .we(p_we), .waddr(p_waddr), .wdata(p_wdata),
        .raddr(p_raddr), .rdata(p_rdata)
    );
    sgdmf_ram #(.WIDTH(32), .DEPTH(QDEPTH)) u_q_ram (
        .clk(clk), .we(q_we), .waddr(q_waddr), .wdata(q_wdata),
        .raddr(q_raddr), .rdata(q_rdata)
    );
    sgdmf_ram #(.WIDTH(32), .DEPTH(LATENT)) u_pcopy_ram (
        .clk(clk), .we(d1_valid_reg), .waddr(d1_k_reg), .wdata(p_rdata),
        .raddr(c_raddr), .rdata(cp_rdata)
    );
    sgdmf_ram #(.WIDTH(32), .DEPTH(LATENT)) u_qcopy_ram (
        .clk(clk), .we(d1_valid_reg), .waddr(d1_k_reg), .wdata(q_rdata),
        .raddr(c_raddr), .rdata(cq_rdata)
    );

    assign res_valid = res_valid_reg;
    assign res       = res_reg;
    assign upd_p     = (cur_reg.op == OP_SMP_P);
    assign start     = cmd_valid && !res_valid_reg;

    assign pa_k = SW'(cur_reg.paddr) + SW'(k_reg);
    assign qa_k = SW'(cur_reg.qaddr) + SW'(k_reg);
    assign pa_w = SW'(cur_reg.paddr) + SW'(u4_k_reg);
    assign qa_w = SW'(cur_reg.qaddr) + SW'(u4_k_reg);

    assign x1 = upd_p ? $signed(cp_rdata) : $signed(cq_rdata);
    assign y1 = upd_p ? $signed(cq_rdata) : $signed(cp_rdata);

    assign d_full = ey_reg - 64'(rx_reg);
    assign delta  = ml_reg[64:16];
    assign new_x  = 64'(x4_reg) + 64'(delta);
    assign sat_x  = sat_w(new_x);
    assign diff   = 64'(cur_reg.value) - sum_reg;
    assign sat_e  = sat_w(diff);

    always_comb
    begin
        state_next      = state_reg;
        cur_next        = cur_reg;
        k_next          = k_reg;
        issue_done_next = issue_done_reg;
        flag_next       = flag_reg;
        err_next        = err_reg;
        sum_next        = sum_reg;
        d1_valid_next   = 1'b0;
        d1_k_next       = k_reg;
        u1_valid_next   = 1'b0;
        u1_k_next       = k_reg;
        res_valid_next  = res_valid_reg && !res_pop;
        res_next        = res_reg;
        cmd_pop         = 1'b0;
        p_we            = 1'b0;
        q_we            = 1'b0;
        p_waddr         = PAW'(cmd.paddr);
        q_waddr         = QAW'(cmd.qaddr);
        p_wdata         = cmd.value;
        q_wdata         = cmd.value;
        p_raddr         = PAW'(cmd.paddr);
        q_raddr         = QAW'(cmd.qaddr);
        c_raddr         = k_reg;

        if (d2_valid_reg)
        begin
            sum_next = sum_reg + (prod_reg >>> 16);
        end

        if (u4_valid_reg)
        begin
            if (upd_p)
            begin
                p_we    = 1'b1;
                p_waddr = pa_w[PAW-1:0];
                p_wdata = sat_x[31:0];
            end
            else
            begin
                q_we    = 1'b1;
                q_waddr = qa_w[QAW-1:0];
                q_wdata = sat_x[31:0];
            end
            flag_next = flag_reg | sat_x[32];
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    cmd_pop  = 1'b1;
                    cur_next = cmd;
                    res_next = '0;
                    case (cmd.op)
                        OP_WR_P:
                        begin
                            p_we           = 1'b1;
                            res_valid_next = 1'b1;
                        end
                        OP_WR_Q:
                        begin
                            q_we           = 1'b1;
                            res_valid_next = 1'b1;
                        end
                        OP_RD_P, OP_RD_Q:
                        begin
                            state_next = ST_READ;
                        end
                        OP_SMP_P, OP_SMP_Q:
                        begin
                            k_next          = '0;
                            issue_done_next = 1'b0;
                            sum_next        = '0;
                            flag_next       = 1'b0;
                            state_next      = ST_DOT;
                        end
                        default:
                        begin
                            res_valid_next = 1'b1;
                        end
                    endcase
                end
            end
            ST_READ:
            begin
                res_next            = '0;
                res_next.read_value = (cur_reg.op == OP_RD_P) ? p_rdata : q_rdata;
                res_valid_next      = 1'b1;
                state_next          = ST_IDLE;
            end
            ST_DOT:
            begin
                p_raddr = pa_k[PAW-1:0];
                q_raddr = qa_k[QAW-1:0];
                if (!issue_done_reg)
                begin
                    d1_valid_next = 1'b1;
                    if (k_reg == KW'(LATENT - 1))
                    begin
                        issue_done_next = 1'b1;
                        k_next          = '0;
                    end
                    else
                    begin
                        k_next = k_reg + 1'b1;
                    end
                end
                else if (!d1_valid_reg && !d2_valid_reg)
                begin
                    state_next = ST_ERR;
                end
            end
            ST_ERR:
            begin
                err_next        = sat_e[31:0];
                flag_next       = sat_e[32];
                issue_done_next = 1'b0;
                k_next          = '0;
                state_next      = ST_UPD;
            end
            ST_UPD:
            begin
                if (!issue_done_reg)
                begin
                    u1_valid_next = 1'b1;
                    if (k_reg == KW'(LATENT - 1))
                    begin
                        issue_done_next = 1'b1;
                        k_next          = '0;
                    end
                    else
                    begin
                        k_next = k_reg + 1'b1;
                    end
                end
                else if (!u1_valid_reg && !u2_valid_reg && !u3_valid_reg && !u4_valid_reg)
                begin
                    res_next.read_value  = '0;
                    res_next.error_value = err_reg;
                    res_next.saturated   = flag_reg;
                    res_valid_next       = 1'b1;
                    state_next           = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            issue_done_reg <= 1'b0;
            d1_valid_reg   <= 1'b0;
            d2_valid_reg   <= 1'b0;
            u1_valid_reg   <= 1'b0;
            u2_valid_reg   <= 1'b0;
            u3_valid_reg   <= 1'b0;
            u4_valid_reg   <= 1'b0;
            res_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            issue_done_reg <= issue_done_next;
            d1_valid_reg   <= d1_valid_next;
            d2_valid_reg   <= d1_valid_reg;
            u1_valid_reg   <= u1_valid_next;
            u2_valid_reg   <= u1_valid_reg;
            u3_valid_reg   <= u2_valid_reg;
            u4_valid_reg   <= u3_valid_reg;
            res_valid_reg  <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg  <= cur_next;
        k_reg    <= k_next;
        flag_reg <= flag_next;
        err_reg  <= err_next;
        sum_reg  <= sum_next;
        res_reg  <= res_next;
        d1_k_reg <= d1_k_next;
        prod_reg <= $signed(p_rdata) * $signed(q_rdata);
        u1_k_reg <= u1_k_next;
        // update pass: err*y and reg*x, then floor, then times lr, then add
        u2_k_reg <= u1_k_reg;
        ey_reg   <= 64'(err_reg) * 64'(y1);
        rx_reg   <= $signed({1'b0, rg}) * x1;
        x2_reg   <= x1;
        u3_k_reg <= u2_k_reg;
        d16_reg  <= d_full[63:16];
        x3_reg   <= x2_reg;
        u4_k_reg <= u3_k_reg;
        ml_reg   <= d16_reg * $signed({1'b0, lr});
        x4_reg   <= x3_reg;
    end

endmodule
`default_nettype wire

@@ rtl/core/sgd_matrix_factor_update_core.sv @@
// SGD matrix-factorisation update core. Requests enter through a small front stage that wraps
// the row, column and lane indices and queues up to two decoded requests; the back end runs
// them one at a time against the P and Q factor RAMs and hands results out through a single
// result register. A word write is done straight from idle in the back end, a word read goes
// through one read state, and a rating sample takes two passes: one pass streams both
// vectors out of the factor RAMs through the dot-product multiply-accumulate, the second pass
// streams the saved copies through a four-stage update pipeline and writes the chosen vector
// back. The factor RAMs have one read and one write port each, which sets the one word per
// cycle in each pass. Factor words read before they were ever written return undefined data.
`default_nettype none
module sgd_matrix_factor_update_core
    import sgdmf_pkg::*;
#(
    parameter int ROWS   = 1024,
    parameter int COLS   = 1024,
    parameter int LATENT = 64
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        push,
    output logic        full,
    input  in_item_t    item,
    output logic        empty,
    input  logic        pop,
    output out_item_t   result
);

    localparam logic [15:0] LR_RESET  = 16'd131;
    localparam logic [15:0] REG_RESET = 16'd3277;

    logic [15:0] lr_reg, rg_reg;
    logic        cfg_wr, cmd_valid, cmd_pop, res_valid;
    cmd_t        cmd;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;
    assign prdata = {16'd0, paddr[2] ? rg_reg : lr_reg};
    assign empty  = !res_valid;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lr_reg <= LR_RESET;
            rg_reg <= REG_RESET;
        end
        else if (cfg_wr)
        begin
            if (paddr[2])
            begin
                rg_reg <= pwdata[15:0];
            end
            else
            begin
                lr_reg <= pwdata[15:0];
            end
        end
    end

    sgdmf_front #(.ROWS(ROWS), .COLS(COLS), .LATENT(LATENT)) u_front (
        .clk(clk), .rst_n(rst_n), .push(push), .full(full), .item(item),
        .cmd_valid(cmd_valid), .cmd(cmd), .cmd_pop(cmd_pop)
    );

    sgdmf_back #(.ROWS(ROWS), .COLS(COLS), .LATENT(LATENT)) u_back (
        .clk(clk), .rst_n(rst_n), .cmd_valid(cmd_valid), .cmd(cmd), .cmd_pop(cmd_pop),
        .lr(lr_reg), .rg(rg_reg), .res_valid(res_valid), .res(result),
        .res_pop(pop && !empty)
    );

    // a result never carries both a read-back and a sample error
    assert property (@(posedge clk) disable iff (!rst_n)
        !empty |-> (result.read_value == 0 || result.error_value == 0))
        else $error("read and error fields both set");

    assert property (@(posedge clk) disable iff (!rst_n)
        !empty && result.read_value != 0 |-> !result.saturated)
        else $error("saturation flagged on a read");

    assert property (@(posedge clk) disable iff (!rst_n)
        cfg_wr && !paddr[2] |=> lr_reg == $past(pwdata[15:0]))
        else $error("learning rate write lost");

endmodule
`default_nettype wire

@@ sim/tb_sgd_matrix_factor_update_core.sv @@
`timescale 1ns / 1ps
module tb_sgd_matrix_factor_update_core
    import sgdmf_pkg::*;
();

    localparam int NLAT = 64;
    localparam int IDLE_LIMIT = 6000;
    localparam int SETTLE = 200;
    localparam logic [2:0] ADDR_LR  = 3'd0;
    localparam logic [2:0] ADDR_REG = 3'd4;
    localparam logic [2:0] KIND_NONE6 = 3'd6;
    localparam logic [2:0] KIND_NONE7 = 3'd7;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;
    logic        push;
    logic        full;
    in_item_t    item;
    logic        empty;
    logic        pop;
    out_item_t   result;

    sgd_matrix_factor_update_core uut (
        .clk(clk), .rst_n(rst_n),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready),
        .push(push), .full(full), .item(item),
        .empty(empty), .pop(pop), .result(result)
    );

    // predictor state
    logic signed [31:0] p_words [0:1024*NLAT-1];
    logic signed [31:0] q_words [0:1024*NLAT-1];
    logic [15:0] lr_q;
    logic [15:0] decay_q;
    out_item_t   pending_results [$];

    // rows/cols whose whole vector is written before any sample touches them
    logic [9:0] vec_pool [0:2] = '{10'd0, 10'd1023, 10'd5};

    bit failed;
    bit apb_busy;
    int idle_cycles;
    int holdoff;
    bit no_gaps;
    int burst_left;

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    function automatic longint clip32(longint v, inout bit flag);
        if (v > 64'sd2147483647)
        begin
            flag = 1'b1;
            return 64'sd2147483647;
        end
        if (v < -64'sd2147483648)
        begin
            flag = 1'b1;
            return -64'sd2147483648;
        end
        return v;
    endfunction

    function automatic out_item_t predict_update(in_item_t req);
        out_item_t res;
        int rbase;
        int cbase;
        longint sum;
        longint err;
        longint x;
        longint y;
        longint d;
        longint delta;
        bit flag;
        logic signed [31:0] pv [NLAT];
        logic signed [31:0] qv [NLAT];
        res = '0;
        flag = 1'b0;
        rbase = int'(req.row) * NLAT;
        cbase = int'(req.col) * NLAT;
        case (req.kind)
            KIND_WR_P: p_words[rbase + req.lane] = req.value;
            KIND_WR_Q: q_words[cbase + req.lane] = req.value;
            KIND_RD_P: res.read_value = p_words[rbase + req.lane];
            KIND_RD_Q: res.read_value = q_words[cbase + req.lane];
            KIND_SMP_P, KIND_SMP_Q:
            begin
                sum = 0;
                for (int k = 0; k < NLAT; k++)
                begin
                    pv[k] = p_words[rbase + k];
                    qv[k] = q_words[cbase + k];
                    sum += (longint'(pv[k]) * longint'(qv[k])) >>> 16;
                end
                err = clip32(longint'(req.value) - sum, flag);
                for (int k = 0; k < NLAT; k++)
                begin
                    x = (req.kind == KIND_SMP_P) ? longint'(pv[k]) : longint'(qv[k]);
                    y = (req.kind == KIND_SMP_P) ? longint'(qv[k]) : longint'(pv[k]);
                    d = err * y - longint'({1'b0, decay_q}) * x;
                    delta = ((d >>> 16) * longint'({1'b0, lr_q})) >>> 16;
                    x = clip32(x + delta, flag);
                    if (req.kind == KIND_SMP_P)
                        p_words[rbase + k] = x[31:0];
                    else
                        q_words[cbase + k] = x[31:0];
                end
                res.error_value = err[31:0];
                res.saturated = flag;
            end
            default: ;
        endcase
        return res;
    endfunction

    // result checker
    always @(posedge clk)
    begin
        out_item_t exp_r;
        if (rst_n && pop && !empty)
        begin
            if (pending_results.size() == 0)
            begin
                $display("%0t: unexpected result %h", $time, result);
                failed = 1'b1;
            end
            else
            begin
                exp_r = pending_results.pop_front();
                if (result.read_value !== exp_r.read_value)
                begin
                    $display("%0t: read_value exp %h got %h", $time,
                             exp_r.read_value, result.read_value);
                    failed = 1'b1;
                end
                if (result.error_value !== exp_r.error_value)
                begin
                    $display("%0t: error_value exp %h got %h", $time,
                             exp_r.error_value, result.error_value);
                    failed = 1'b1;
                end
                if (result.saturated !== exp_r.saturated)
                begin
                    $display("%0t: saturated exp %b got %b", $time,
                             exp_r.saturated, result.saturated);
                    failed = 1'b1;
                end
            end
        end
    end

    // watchdog on accepted traffic
    always @(posedge clk)
    begin
        if ((push && !full) || (pop && !empty) || apb_busy || !rst_n)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > IDLE_LIMIT)
        begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    // receiver: stall pattern in phases, plus counted hold-off
    always @(negedge clk)
    begin
        int phase_left;
        int mode;
        if (!rst_n)
        begin
            pop = 1'b0;
        end
        else if (holdoff > 0)
        begin
            holdoff = holdoff - 1;
            pop = 1'b0;
        end
        else
        begin
            if (phase_left <= 0)
            begin
                phase_left = $urandom_range(10, 300);
                mode = $urandom_range(0, 3);
            end
            phase_left = phase_left - 1;
            case (mode)
                0: pop = 1'b1;
                1: pop = ($urandom_range(0, 3) != 0);
                2: pop = ($urandom_range(0, 3) == 0);
                default: pop = ($urandom_range(0, 30) == 0);
            endcase
        end
    end

    task automatic send_request(in_item_t req);
        if (!no_gaps && burst_left <= 0)
        begin
            burst_left = $urandom_range(1, 12);
            repeat ($urandom_range(0, 8))
            begin
                @(negedge clk);
                push = 1'b0;
            end
        end
        burst_left = burst_left - 1;
        @(negedge clk);
        push = 1'b1;
        item = req;
        forever
        begin
            @(posedge clk);
            if (!full)
                break;
        end
        pending_results.insert(pending_results.size(), predict_update(req));
    endtask

    task automatic drain;
        @(negedge clk);
        push = 1'b0;
        wait (pending_results.size() == 0);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic reg_write(logic [2:0] addr, logic [15:0] data);
        @(negedge clk);
        apb_busy = 1'b1;
        psel = 1'b1;
        penable = 1'b0;
        pwrite = 1'b1;
        paddr = addr;
        pwdata = {16'($urandom_range(0, 65535)), data};
        @(negedge clk);
        penable = 1'b1;
        @(posedge clk);
        if (addr == ADDR_LR)
            lr_q = data;
        else
            decay_q = data;
        @(negedge clk);
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        apb_busy = 1'b0;
    endtask

    task automatic set_rates(logic [15:0] lr, logic [15:0] dk);
        drain();
        reg_write(ADDR_LR, lr);
        reg_write(ADDR_REG, dk);
    endtask

    function automatic logic signed [31:0] pick_value();
        case ($urandom_range(0, 9))
            0: return 32'sh7fffffff;
            1: return 32'sh80000000;
            2, 3: return $urandom();
            default: return $signed($urandom_range(0, 32'h3ffff)) - 32'sh20000;
        endcase
    endfunction

    function automatic in_item_t make_req(logic [2:0] k, logic [9:0] r, logic [9:0] c,
                                          logic [5:0] ln, logic signed [31:0] v);
        in_item_t req;
        req.kind = k;
        req.row = r;
        req.col = c;
        req.lane = ln;
        req.value = v;
        return req;
    endfunction

    task automatic test_fill_vectors;
        for (int v = 0; v < 3; v++)
            for (int k = 0; k < NLAT; k++)
            begin
                send_request(make_req(KIND_WR_P, vec_pool[v], 10'($urandom()), 6'(k),
                                      $signed($urandom_range(0, 32'h1ffff)) - 32'sh10000));
                send_request(make_req(KIND_WR_Q, 10'($urandom()), vec_pool[v], 6'(k),
                                      $signed($urandom_range(0, 32'h1ffff)) - 32'sh10000));
            end
    endtask

    task automatic test_directed;
        send_request(make_req(KIND_WR_P, 10'd1023, 10'd0, 6'd63, 32'sh7fffffff));
        send_request(make_req(KIND_RD_P, 10'd1023, 10'd1023, 6'd63, 32'sh0));
        send_request(make_req(KIND_WR_Q, 10'd0, 10'd1023, 6'd63, 32'sh80000000));
        send_request(make_req(KIND_RD_Q, 10'd1023, 10'd1023, 6'd63, 32'shffffffff));
        send_request(make_req(KIND_WR_P, 10'd0, 10'd0, 6'd0, 32'sh0));
        send_request(make_req(KIND_RD_P, 10'd0, 10'd0, 6'd0, 32'sh0));
        send_request(make_req(KIND_NONE6, 10'd1023, 10'd1023, 6'd63, 32'shffffffff));
        send_request(make_req(KIND_NONE7, 10'd0, 10'd0, 6'd0, 32'sh0));
        // clipped error and clipped words
        send_request(make_req(KIND_SMP_P, 10'd1023, 10'd1023, 6'd0, 32'sh7fffffff));
        send_request(make_req(KIND_SMP_Q, 10'd1023, 10'd1023, 6'd63, 32'sh80000000));
        send_request(make_req(KIND_SMP_P, 10'd0, 10'd0, 6'd0, 32'sh0));
        send_request(make_req(KIND_SMP_Q, 10'd5, 10'd0, 6'd0, 32'sh00010000));
        send_request(make_req(KIND_RD_P, 10'd1023, 10'd0, 6'd63, 32'sh0));
        send_request(make_req(KIND_RD_Q, 10'd0, 10'd1023, 6'd0, 32'sh0));
    endtask

    task automatic test_random(int count);
        int dice;
        logic [9:0] r;
        logic [9:0] c;
        for (int n = 0; n < count; n++)
        begin
            dice = $urandom_range(0, 99);
            r = vec_pool[$urandom_range(0, 2)];
            c = vec_pool[$urandom_range(0, 2)];
            if (dice < 20)
                send_request(make_req(KIND_WR_P, r, 10'($urandom()), 6'($urandom()),
                                      pick_value()));
            else if (dice < 40)
                send_request(make_req(KIND_WR_Q, 10'($urandom()), c, 6'($urandom()),
                                      pick_value()));
            else if (dice < 52)
                send_request(make_req(KIND_SMP_P, r, c, 6'($urandom()), pick_value()));
            else if (dice < 64)
                send_request(make_req(KIND_SMP_Q, r, c, 6'($urandom()), pick_value()));
            else if (dice < 78)
                send_request(make_req(KIND_RD_P, r, 10'($urandom()), 6'($urandom()),
                                      $urandom()));
            else if (dice < 92)
                send_request(make_req(KIND_RD_Q, 10'($urandom()), c, 6'($urandom()),
                                      $urandom()));
            else if (dice < 96)
                send_request(make_req(KIND_NONE6, 10'($urandom()), 10'($urandom()),
                                      6'($urandom()), $urandom()));
            else
                send_request(make_req(KIND_NONE7, 10'($urandom()), 10'($urandom()),
                                      6'($urandom()), $urandom()));
        end
    endtask

    task automatic test_backpressure;
        holdoff = 900;
        no_gaps = 1'b1;
        test_random(40);
        no_gaps = 1'b0;
        drain();
    endtask

    initial
    begin
        rst_n = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        push = 1'b0;
        item = '0;
        pop = 1'b0;
        failed = 1'b0;
        apb_busy = 1'b0;
        holdoff = 0;
        no_gaps = 1'b0;
        burst_left = 0;
        lr_q = 16'd131;
        decay_q = 16'd3277;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_fill_vectors();
        test_directed();
        test_random(120);
        set_rates(16'd0, 16'd0);
        test_random(100);
        set_rates(16'hffff, 16'hffff);
        test_random(100);
        test_backpressure();
        set_rates(16'($urandom()), 16'($urandom()));
        test_random(100);
        set_rates(16'hffff, 16'd0);
        test_random(80);
        set_rates(16'd131, 16'd3277);
        test_random(160);

        drain();
        if (!failed && pending_results.size() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

@@ sgd_matrix_factor_update_core.f @@
rtl/core/sgdmf_pkg.sv
rtl/core/sgdmf_ram.sv
rtl/core/sgdmf_front.sv
rtl/core/sgdmf_back.sv
rtl/core/sgd_matrix_factor_update_core.sv
sim/tb_sgd_matrix_factor_update_core.sv
